/* hdl/cstok_pkg.sv */
`timescale 1ns / 1ps
// cstok_pkg: shared constants and types of the character stream tokenizer
// token kind codes, port widths, parameter defaults, result word types; no dependencies

package cstok_pkg;

  localparam int MAX_LEN_BITS_DEF  = 16;
  localparam int POS_BITS_DEF      = 32;
  localparam int KEYWORD_CHARS_DEF = 6;

  localparam int KIND_W     = 5;
  localparam int POS_PORT_W = 32;
  localparam int LEN_PORT_W = 16;
  localparam int RES_SLOTS  = 3;

  localparam logic [KIND_W-1:0] KIND_VARIABLE  = 5'd0;
  localparam logic [KIND_W-1:0] KIND_INTEGER   = 5'd1;
  localparam logic [KIND_W-1:0] KIND_POINTED   = 5'd2;
  localparam logic [KIND_W-1:0] KIND_PLUS      = 5'd3;
  localparam logic [KIND_W-1:0] KIND_SUB       = 5'd4;
  localparam logic [KIND_W-1:0] KIND_DIV       = 5'd5;
  localparam logic [KIND_W-1:0] KIND_EXP       = 5'd6;
  localparam logic [KIND_W-1:0] KIND_MULTI     = 5'd7;
  localparam logic [KIND_W-1:0] KIND_STRING    = 5'd8;
  localparam logic [KIND_W-1:0] KIND_RESERVED  = 5'd9;
  localparam logic [KIND_W-1:0] KIND_END       = 5'd10;
  localparam logic [KIND_W-1:0] KIND_LESS      = 5'd11;
  localparam logic [KIND_W-1:0] KIND_GREATER   = 5'd12;
  localparam logic [KIND_W-1:0] KIND_LBRACKET  = 5'd13;
  localparam logic [KIND_W-1:0] KIND_RBRACKET  = 5'd14;
  localparam logic [KIND_W-1:0] KIND_LPAREN    = 5'd15;
  localparam logic [KIND_W-1:0] KIND_RPAREN    = 5'd16;
  localparam logic [KIND_W-1:0] KIND_LBRACE    = 5'd17;
  localparam logic [KIND_W-1:0] KIND_RBRACE    = 5'd18;
  localparam logic [KIND_W-1:0] KIND_SEMICOLON = 5'd19;
  localparam logic [KIND_W-1:0] KIND_ASSIGN    = 5'd20;
  localparam logic [KIND_W-1:0] KIND_LESS_EQ   = 5'd21;
  localparam logic [KIND_W-1:0] KIND_GREATER_EQ = 5'd22;
  localparam logic [KIND_W-1:0] KIND_IF        = 5'd23;
  localparam logic [KIND_W-1:0] KIND_FOR       = 5'd24;
  localparam logic [KIND_W-1:0] KIND_WHILE     = 5'd25;
  localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 5'd26;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [POS_PORT_W-1:0] start_pos;
    logic [LEN_PORT_W-1:0] length;
    logic                  sat;
  } res_t;

  // up to three results per character, in order: pending, own or final flush, end
  typedef struct packed {
    logic [RES_SLOTS-1:0]        mask;
    res_t [RES_SLOTS-1:0]        item;
  } res_group_t;

endpackage

/* hdl/cstok_scan.sv */
`timescale 1ns / 1ps
// cstok_scan: scanner state and the per-character decision logic
// produces the result group of one character; depends on cstok_pkg

module cstok_scan #(
  parameter int MAX_LEN_BITS  = cstok_pkg::MAX_LEN_BITS_DEF,
  parameter int POS_BITS      = cstok_pkg::POS_BITS_DEF,
  parameter int KEYWORD_CHARS = cstok_pkg::KEYWORD_CHARS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             ch,
  input  logic                   last_char,
  input  logic                   advance,
  output cstok_pkg::res_group_t  group
);

  localparam int LW = MAX_LEN_BITS;
  localparam int PW = POS_BITS;
  localparam int KC = KEYWORD_CHARS;

  typedef enum logic [5:0] {
    M_IDLE = 6'b000001,
    M_NUM  = 6'b000010,
    M_WORD = 6'b000100,
    M_STR  = 6'b001000,
    M_LT   = 6'b010000,
    M_GT   = 6'b100000
  } mode_t;

  mode_t               mode;
  logic [LW-1:0]       tok_len;
  logic [PW-1:0]       tok_start;
  logic [PW-1:0]       stream_pos;
  logic                seen_dot;
  logic                len_sat;
  logic [KC-1:0][7:0]  word_prefix;

  mode_t               mode_next;
  logic [LW-1:0]       tok_len_next;
  logic [PW-1:0]       tok_start_next;
  logic [PW-1:0]       stream_pos_next;
  logic                seen_dot_next;
  logic                len_sat_next;
  logic [KC-1:0][7:0]  word_prefix_next;

  mode_t               mode_a;
  mode_t               mode_b;
  logic [LW-1:0]       len_a;
  logic [LW-1:0]       len_b;
  logic                sat_a;
  logic                sat_b;
  logic                seen_a;
  logic                seen_b;
  logic [KC-1:0][7:0]  pre_a;
  logic [KC-1:0][7:0]  pre_b;
  logic [PW-1:0]       start_b;
  logic [PW-1:0]       pos_inc;
  logic                again;

  logic                          s0_v;
  logic [cstok_pkg::KIND_W-1:0]  s0_kind;
  logic [PW-1:0]                 s0_start;
  logic [LW-1:0]                 s0_len;
  logic                          s0_sat;
  logic                          s1_v;
  logic [cstok_pkg::KIND_W-1:0]  s1_kind;
  logic [PW-1:0]                 s1_start;
  logic [LW-1:0]                 s1_len;
  logic                          s1_sat;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [LW-1:0] len_of(input int n);
    return LW'(n);
  endfunction

  function automatic logic [cstok_pkg::LEN_PORT_W-1:0] len_port(input logic [LW-1:0] v);
    logic [LW+cstok_pkg::LEN_PORT_W-1:0] t;
    t = {{cstok_pkg::LEN_PORT_W{1'b0}}, v};
    return t[cstok_pkg::LEN_PORT_W-1:0];
  endfunction

  function automatic logic [cstok_pkg::POS_PORT_W-1:0] pos_port(input logic [PW-1:0] v);
    logic [PW+cstok_pkg::POS_PORT_W-1:0] t;
    t = {{cstok_pkg::POS_PORT_W{1'b0}}, v};
    return t[cstok_pkg::POS_PORT_W-1:0];
  endfunction

  function automatic logic [cstok_pkg::KIND_W-1:0] op_kind(input logic [7:0] c);
    logic [cstok_pkg::KIND_W-1:0] k;
    unique case (c)
      "+":     k = cstok_pkg::KIND_PLUS;
      "-":     k = cstok_pkg::KIND_SUB;
      "/":     k = cstok_pkg::KIND_DIV;
      "^":     k = cstok_pkg::KIND_EXP;
      "*":     k = cstok_pkg::KIND_MULTI;
      "[":     k = cstok_pkg::KIND_LBRACKET;
      "]":     k = cstok_pkg::KIND_RBRACKET;
      "(":     k = cstok_pkg::KIND_LPAREN;
      ")":     k = cstok_pkg::KIND_RPAREN;
      "{":     k = cstok_pkg::KIND_LBRACE;
      "}":     k = cstok_pkg::KIND_RBRACE;
      ";":     k = cstok_pkg::KIND_SEMICOLON;
      "=":     k = cstok_pkg::KIND_ASSIGN;
      default: k = cstok_pkg::KIND_NOT_FOUND;
    endcase
    return k;
  endfunction

  // keyword lookup on the stored prefix, exact length only
  function automatic logic [cstok_pkg::KIND_W-1:0] kw_kind(
    input logic [5:0][7:0] p,
    input logic [LW-1:0]   len,
    input logic            sat
  );
    logic [cstok_pkg::KIND_W-1:0] k;
    k = cstok_pkg::KIND_VARIABLE;
    if (!sat && (len < len_of(8))) begin
      unique case (len[2:0])
        3'd2: begin
          if ({p[0], p[1]} == "if") k = cstok_pkg::KIND_IF;
        end
        3'd3: begin
          if ({p[0], p[1], p[2]} == "int") k = cstok_pkg::KIND_RESERVED;
          else if ({p[0], p[1], p[2]} == "for") k = cstok_pkg::KIND_FOR;
        end
        3'd4: begin
          if ({p[0], p[1], p[2], p[3]} == "auto") k = cstok_pkg::KIND_RESERVED;
          else if ({p[0], p[1], p[2], p[3]} == "char") k = cstok_pkg::KIND_RESERVED;
        end
        3'd5: begin
          if ({p[0], p[1], p[2], p[3], p[4]} == "float") k = cstok_pkg::KIND_RESERVED;
          else if ({p[0], p[1], p[2], p[3], p[4]} == "while") k = cstok_pkg::KIND_WHILE;
        end
        3'd6: begin
          if ({p[0], p[1], p[2], p[3], p[4], p[5]} == "string") k = cstok_pkg::KIND_RESERVED;
        end
        default: k = cstok_pkg::KIND_VARIABLE;
      endcase
    end
    return k;
  endfunction

  function automatic logic [cstok_pkg::KIND_W-1:0] flush_kind(
    input mode_t           m,
    input logic            seen,
    input logic            sat,
    input logic [LW-1:0]   len,
    input logic [5:0][7:0] p
  );
    logic [cstok_pkg::KIND_W-1:0] k;
    unique case (m)
      M_NUM:   k = seen ? cstok_pkg::KIND_POINTED : cstok_pkg::KIND_INTEGER;
      M_WORD:  k = kw_kind(p, len, sat);
      M_STR:   k = cstok_pkg::KIND_STRING;
      M_LT:    k = cstok_pkg::KIND_LESS;
      M_GT:    k = cstok_pkg::KIND_GREATER;
      default: k = cstok_pkg::KIND_VARIABLE;
    endcase
    return k;
  endfunction

  always_comb begin
    // pending token
    mode_a   = mode;
    len_a    = tok_len;
    sat_a    = len_sat;
    seen_a   = seen_dot;
    pre_a    = word_prefix;
    again    = 1'b0;
    s0_v     = 1'b0;
    s0_kind  = flush_kind(mode, seen_dot, len_sat, tok_len, word_prefix[5:0]);
    s0_start = tok_start;
    s0_len   = tok_len;
    s0_sat   = len_sat;
    unique case (mode)
      M_LT, M_GT: begin
        s0_v   = 1'b1;
        mode_a = M_IDLE;
        if (ch == "=") begin
          s0_kind = (mode == M_LT) ? cstok_pkg::KIND_LESS_EQ : cstok_pkg::KIND_GREATER_EQ;
          s0_len  = len_of(2);
          s0_sat  = 1'b0;
        end else begin
          again = 1'b1;
        end
      end
      M_NUM: begin
        if (is_digit(ch) || ((ch == ".") && !seen_dot)) begin
          if (ch == ".") seen_a = 1'b1;
          if (&tok_len) sat_a = 1'b1;
          else len_a = tok_len + len_of(1);
        end else begin
          s0_v   = 1'b1;
          mode_a = M_IDLE;
          again  = 1'b1;
        end
      end
      M_WORD: begin
        if (is_digit(ch) || is_letter(ch)) begin
          for (int i = 0; i < KC; i++) begin
            if (tok_len == len_of(i)) pre_a[i] = ch;
          end
          if (&tok_len) sat_a = 1'b1;
          else len_a = tok_len + len_of(1);
        end else begin
          s0_v   = 1'b1;
          mode_a = M_IDLE;
          again  = 1'b1;
        end
      end
      M_STR: begin
        if (ch == "\"") begin
          s0_v   = 1'b1;
          mode_a = M_IDLE;
        end else if (&tok_len) begin
          sat_a = 1'b1;
        end else begin
          len_a = tok_len + len_of(1);
        end
      end
      default: begin
        mode_a = M_IDLE;
        again  = 1'b1;
      end
    endcase

    // character scanned from idle
    mode_b   = mode_a;
    start_b  = tok_start;
    len_b    = len_a;
    sat_b    = sat_a;
    seen_b   = seen_a;
    pre_b    = pre_a;
    s1_v     = 1'b0;
    s1_kind  = op_kind(ch);
    s1_start = stream_pos;
    s1_len   = len_of(1);
    s1_sat   = 1'b0;
    if (again) begin
      if (is_digit(ch) || is_letter(ch) || (ch == "\"") || (ch == "<") || (ch == ">")) begin
        start_b = stream_pos;
        len_b   = (ch == "\"") ? len_of(0) : len_of(1);
        sat_b   = 1'b0;
        seen_b  = 1'b0;
        pre_b   = '0;
        if (is_digit(ch)) begin
          mode_b = M_NUM;
        end else if (is_letter(ch)) begin
          mode_b   = M_WORD;
          pre_b[0] = ch;
        end else if (ch == "\"") begin
          mode_b = M_STR;
        end else if (ch == "<") begin
          mode_b = M_LT;
        end else begin
          mode_b = M_GT;
        end
      end else if (!is_space(ch)) begin
        s1_v = 1'b1;
      end
    end

    // end of stream flush
    pos_inc = stream_pos + PW'(1);
    if (last_char && (mode_b != M_IDLE)) begin
      s1_v     = 1'b1;
      s1_kind  = flush_kind(mode_b, seen_b, sat_b, len_b, pre_b[5:0]);
      s1_start = start_b;
      s1_len   = len_b;
      s1_sat   = sat_b;
    end

    if (last_char) begin
      mode_next        = M_IDLE;
      tok_len_next     = '0;
      tok_start_next   = '0;
      stream_pos_next  = '0;
      seen_dot_next    = 1'b0;
      len_sat_next     = 1'b0;
      word_prefix_next = '0;
    end else begin
      mode_next        = mode_b;
      tok_len_next     = len_b;
      tok_start_next   = start_b;
      stream_pos_next  = pos_inc;
      seen_dot_next    = seen_b;
      len_sat_next     = sat_b;
      word_prefix_next = pre_b;
    end
  end

  assign group.mask = {last_char, s1_v, s0_v};
  assign group.item[0] = '{kind: s0_kind, start_pos: pos_port(s0_start),
                           length: len_port(s0_len), sat: s0_sat};
  assign group.item[1] = '{kind: s1_kind, start_pos: pos_port(s1_start),
                           length: len_port(s1_len), sat: s1_sat};
  assign group.item[2] = '{kind: cstok_pkg::KIND_END, start_pos: pos_port(pos_inc),
                           length: '0, sat: 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_IDLE;
      tok_len     <= '0;
      tok_start   <= '0;
      stream_pos  <= '0;
      seen_dot    <= 1'b0;
      len_sat     <= 1'b0;
      word_prefix <= '0;
    end else if (advance) begin
      mode        <= mode_next;
      tok_len     <= tok_len_next;
      tok_start   <= tok_start_next;
      stream_pos  <= stream_pos_next;
      seen_dot    <= seen_dot_next;
      len_sat     <= len_sat_next;
      word_prefix <= word_prefix_next;
    end
  end

  a_stream_restart: assert property (@(posedge clk) disable iff (rst)
    (advance && last_char) |=> ((mode == M_IDLE) && (stream_pos == '0) && (tok_len == '0)))
    else $error("scanner not back at stream start after last character");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (advance && !last_char) |=> (stream_pos == $past(stream_pos) + PW'(1)))
    else $error("stream position did not step by one");

endmodule

/* hdl/cstok_out_buf.sv */
`timescale 1ns / 1ps
// cstok_out_buf: result register holding the words of one character
// hands them out one per cycle while out_ready is high, in order; depends on cstok_pkg

module cstok_out_buf (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cstok_pkg::res_group_t                 group,
  input  logic                                  load,
  output logic                                  free,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [cstok_pkg::KIND_W-1:0]          kind,
  output logic [cstok_pkg::POS_PORT_W-1:0]      start_pos,
  output logic [cstok_pkg::LEN_PORT_W-1:0]      length,
  output logic                                  length_saturated,
  output logic                                  last_of_run
);

  logic [cstok_pkg::RES_SLOTS-1:0]        mask;
  logic [cstok_pkg::RES_SLOTS-1:0]        mask_next;
  cstok_pkg::res_t [cstok_pkg::RES_SLOTS-1:0] item;
  logic [1:0]                             sel;
  logic                                   single;
  logic                                   take;

  always_comb begin
    priority if (mask[0]) sel = 2'd0;
    else if (mask[1]) sel = 2'd1;
    else sel = 2'd2;
  end

  assign single    = (mask & (mask - 3'd1)) == 3'd0;
  assign out_valid = |mask;
  assign take      = out_valid && out_ready;
  assign free      = !out_valid || (take && single);

  assign kind             = item[sel].kind;
  assign start_pos        = item[sel].start_pos;
  assign length           = item[sel].length;
  assign length_saturated = item[sel].sat;
  assign last_of_run      = single;

  // lowest pending word leaves first
  always_comb begin
    if (load) mask_next = group.mask;
    else if (take) mask_next = mask & (mask - 3'd1);
    else mask_next = mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= group.item;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (free && (group.mask != '0)))
    else $error("result group loaded over pending words");

  a_drain_one: assert property (@(posedge clk) disable iff (rst)
    (take && !single && !load) |=> ($countones(mask) == $past($countones(mask)) - 1))
    else $error("taken word not removed exactly once");

endmodule

/* hdl/char_stream_tokenizer.sv */
`timescale 1ns / 1ps
// order: an accepted character is held in the input register, then its words go to the result register
// throughput: one character per cycle while the result register is free; a character giving
//   several words holds input until its last is taken, one per cycle while out_ready is high
// reset: synchronous rst clears the input stage, scanner state and pending words
// top level of the character stream tokenizer; depends on cstok_pkg, cstok_scan, cstok_out_buf

module char_stream_tokenizer #(
  parameter int MAX_LEN_BITS  = cstok_pkg::MAX_LEN_BITS_DEF,
  parameter int POS_BITS      = cstok_pkg::POS_BITS_DEF,
  parameter int KEYWORD_CHARS = cstok_pkg::KEYWORD_CHARS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        ch,
  input  logic                              last_char,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cstok_pkg::KIND_W-1:0]      kind,
  output logic [cstok_pkg::POS_PORT_W-1:0]  start_pos,
  output logic [cstok_pkg::LEN_PORT_W-1:0]  length,
  output logic                              length_saturated,
  output logic                              last_of_run
);

  logic                  in_held;
  logic [7:0]            ch_q;
  logic                  last_q;
  logic                  advance;
  logic                  buf_free;
  cstok_pkg::res_group_t group;

  assign advance  = in_held && ((group.mask == '0) || buf_free);
  assign in_ready = !in_held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_held <= 1'b1;
    end else if (advance) begin
      in_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_q   <= ch;
      last_q <= last_char;
    end
  end

  cstok_scan #(
    .MAX_LEN_BITS  (MAX_LEN_BITS),
    .POS_BITS      (POS_BITS),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ch        (ch_q),
    .last_char (last_q),
    .advance   (advance),
    .group     (group)
  );

  cstok_out_buf u_out_buf (
    .clk              (clk),
    .rst              (rst),
    .group            (group),
    .load             (advance && (group.mask != '0)),
    .free             (buf_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .start_pos        (start_pos),
    .length           (length),
    .length_saturated (length_saturated),
    .last_of_run      (last_of_run)
  );

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking testbench for char_stream_tokenizer, predicts every token word per character
// depends on cstok_pkg and char_stream_tokenizer; directed streams, one long string, random streams

module tb;

  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_CHARS = 320;
  localparam int LONG_STRING_CHARS = 40;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_NUM, SCAN_WORD, SCAN_STR, SCAN_LT, SCAN_GT
  } scan_mode_t;

  typedef struct packed {
    logic [cstok_pkg::KIND_W-1:0]     kind;
    logic [cstok_pkg::POS_PORT_W-1:0] start_pos;
    logic [cstok_pkg::LEN_PORT_W-1:0] length;
    logic                             sat;
    logic                             last;
  } token_t;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [7:0]                       ch = 8'h00;
  logic                             last_char = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [cstok_pkg::KIND_W-1:0]     kind;
  logic [cstok_pkg::POS_PORT_W-1:0] start_pos;
  logic [cstok_pkg::LEN_PORT_W-1:0] length;
  logic                             length_saturated;
  logic                             last_of_run;

  // predictor state
  scan_mode_t      mode;
  logic [7:0]      word_prefix [6];
  logic [15:0]     tok_len;
  logic [31:0]     tok_start;
  logic [31:0]     stream_pos;
  logic            seen_dot;
  logic            len_sat;

  token_t          char_tokens [$];
  token_t          pending_tokens [$];
  logic [7:0]      stream_text [$];
  string           keyword_list [8] = '{"float", "int", "string", "auto", "char", "while",
                                        "for", "if"};
  int              mismatch_count = 0;
  int              quiet_cycles = 0;
  int              chars_sent = 0;
  int              out_stall = 0;
  bit              no_idle = 1'b0;

  char_stream_tokenizer DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .ch(ch),
    .last_char(last_char),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .start_pos(start_pos),
    .length(length),
    .length_saturated(length_saturated),
    .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void emit_token(logic [cstok_pkg::KIND_W-1:0] k, logic [31:0] s,
                                     logic [15:0] n, logic sat);
    token_t t;
    t.kind = k;
    t.start_pos = s;
    t.length = n;
    t.sat = sat;
    t.last = 1'b0;
    char_tokens.push_back(t);
  endfunction

  function automatic void open_token(scan_mode_t m, logic [31:0] s, logic [15:0] n);
    int i;
    mode = m;
    tok_start = s;
    tok_len = n;
    seen_dot = 1'b0;
    len_sat = 1'b0;
    for (i = 0; i < 6; i++) word_prefix[i] = 8'h00;
  endfunction

  function automatic void lengthen_token();
    if (tok_len == 16'hFFFF) len_sat = 1'b1;
    else tok_len = tok_len + 16'd1;
  endfunction

  function automatic void close_token();
    logic [cstok_pkg::KIND_W-1:0] k;
    logic [47:0] w;
    k = cstok_pkg::KIND_VARIABLE;
    w = {word_prefix[0], word_prefix[1], word_prefix[2], word_prefix[3], word_prefix[4],
         word_prefix[5]};
    case (mode)
      SCAN_NUM: k = seen_dot ? cstok_pkg::KIND_POINTED : cstok_pkg::KIND_INTEGER;
      SCAN_WORD: begin
        if (!len_sat) begin
          case (tok_len)
            16'd2: if (w[47:32] == "if") k = cstok_pkg::KIND_IF;
            16'd3: begin
              if (w[47:24] == "int") k = cstok_pkg::KIND_RESERVED;
              else if (w[47:24] == "for") k = cstok_pkg::KIND_FOR;
            end
            16'd4: begin
              if (w[47:16] == "auto" || w[47:16] == "char") k = cstok_pkg::KIND_RESERVED;
            end
            16'd5: begin
              if (w[47:8] == "float") k = cstok_pkg::KIND_RESERVED;
              else if (w[47:8] == "while") k = cstok_pkg::KIND_WHILE;
            end
            16'd6: if (w == "string") k = cstok_pkg::KIND_RESERVED;
            default: k = cstok_pkg::KIND_VARIABLE;
          endcase
        end
      end
      SCAN_STR: k = cstok_pkg::KIND_STRING;
      SCAN_LT: k = cstok_pkg::KIND_LESS;
      SCAN_GT: k = cstok_pkg::KIND_GREATER;
      default: return;
    endcase
    emit_token(k, tok_start, tok_len, len_sat);
    mode = SCAN_IDLE;
  endfunction

  function automatic void tokenize_char(logic [7:0] c, logic lst);
    logic [31:0] pos;
    logic rescan;
    logic [cstok_pkg::KIND_W-1:0] op;
    token_t t;
    pos = stream_pos;
    rescan = 1'b0;
    case (mode)
      SCAN_LT, SCAN_GT: begin
        if (c == "=") begin
          emit_token(mode == SCAN_LT ? cstok_pkg::KIND_LESS_EQ : cstok_pkg::KIND_GREATER_EQ,
                     tok_start, 16'd2, 1'b0);
          mode = SCAN_IDLE;
        end else begin
          close_token();
          rescan = 1'b1;
        end
      end
      SCAN_NUM: begin
        if (is_digit(c)) begin
          lengthen_token();
        end else if (c == "." && !seen_dot) begin
          seen_dot = 1'b1;
          lengthen_token();
        end else begin
          close_token();
          rescan = 1'b1;
        end
      end
      SCAN_WORD: begin
        if (is_digit(c) || is_letter(c)) begin
          if (tok_len < 16'd6) word_prefix[tok_len[2:0]] = c;
          lengthen_token();
        end else begin
          close_token();
          rescan = 1'b1;
        end
      end
      SCAN_STR: begin
        if (c == "\"") close_token();
        else lengthen_token();
      end
      default: rescan = 1'b1;
    endcase

    if (rescan) begin
      if (is_digit(c)) begin
        open_token(SCAN_NUM, pos, 16'd1);
      end else if (is_letter(c)) begin
        open_token(SCAN_WORD, pos, 16'd1);
        word_prefix[0] = c;
      end else if (c == "\"") begin
        open_token(SCAN_STR, pos, 16'd0);
      end else if (c == "<") begin
        open_token(SCAN_LT, pos, 16'd1);
      end else if (c == ">") begin
        open_token(SCAN_GT, pos, 16'd1);
      end else if (!is_space(c)) begin
        case (c)
          "+": op = cstok_pkg::KIND_PLUS;
          "-": op = cstok_pkg::KIND_SUB;
          "/": op = cstok_pkg::KIND_DIV;
          "^": op = cstok_pkg::KIND_EXP;
          "*": op = cstok_pkg::KIND_MULTI;
          "[": op = cstok_pkg::KIND_LBRACKET;
          "]": op = cstok_pkg::KIND_RBRACKET;
          "(": op = cstok_pkg::KIND_LPAREN;
          ")": op = cstok_pkg::KIND_RPAREN;
          "{": op = cstok_pkg::KIND_LBRACE;
          "}": op = cstok_pkg::KIND_RBRACE;
          ";": op = cstok_pkg::KIND_SEMICOLON;
          "=": op = cstok_pkg::KIND_ASSIGN;
          default: op = cstok_pkg::KIND_NOT_FOUND;
        endcase
        emit_token(op, pos, 16'd1, 1'b0);
      end
    end

    stream_pos = pos + 32'd1;

    if (lst) begin
      close_token();
      emit_token(cstok_pkg::KIND_END, stream_pos, 16'd0, 1'b0);
      open_token(SCAN_IDLE, 32'd0, 16'd0);
      stream_pos = 32'd0;
    end

    if (char_tokens.size() > 0) begin
      t = char_tokens.pop_back();
      t.last = 1'b1;
      char_tokens.push_back(t);
    end
    while (char_tokens.size() > 0) pending_tokens.push_back(char_tokens.pop_front());
  endfunction

  // entered and left at a falling edge
  task automatic send_char(input logic [7:0] c, input logic lst);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    last_char <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tokenize_char(c, lst);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_stream();
    int i;
    for (i = 0; i < stream_text.size(); i++) send_char(stream_text[i], i == stream_text.size() - 1);
  endtask

  function automatic void load_text(string s);
    int i;
    stream_text.delete();
    for (i = 0; i < s.len(); i++) stream_text.push_back(s[i]);
  endfunction

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_tokens.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] random_letter();
    logic [7:0] b;
    b = 8'($urandom_range(0, 25));
    return $urandom_range(0, 1) ? b + "a" : b + "A";
  endfunction

  function automatic logic [7:0] random_alnum();
    logic [7:0] b;
    b = 8'($urandom_range(0, 9));
    return $urandom_range(0, 2) == 0 ? b + "0" : random_letter();
  endfunction

  function automatic void append_digits(int lo, int hi);
    int i;
    int n;
    logic [7:0] b;
    n = $urandom_range(lo, hi);
    for (i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 9));
      stream_text.push_back(b + "0");
    end
  endfunction

  function automatic void append_space();
    logic [7:0] b;
    b = 8'($urandom_range(8, 13));
    stream_text.push_back(b == 8'd8 ? " " : b);
  endfunction

  function automatic void append_token();
    string kw;
    string ops;
    int i;
    int n;
    int mutate;
    logic [7:0] b;
    ops = "+-*/^;=[](){}<>";
    case ($urandom_range(0, 11))
      0, 1: begin
        kw = keyword_list[$urandom_range(0, 7)];
        mutate = $urandom_range(0, 5);
        n = kw.len();
        if (mutate == 0) n--;
        for (i = 0; i < n; i++) begin
          b = kw[i];
          if (i == 0 && mutate == 1) b = b - 8'd32;
          stream_text.push_back(b);
        end
        if (mutate == 2) stream_text.push_back(random_alnum());
      end
      2: begin
        stream_text.push_back(random_letter());
        n = $urandom_range(0, 8);
        for (i = 0; i < n; i++) stream_text.push_back(random_alnum());
      end
      3: append_digits(1, 5);
      4: begin
        append_digits(1, 3);
        stream_text.push_back(".");
        append_digits(0, 3);
        if ($urandom_range(0, 3) == 0) begin
          stream_text.push_back(".");
          append_digits(0, 2);
        end
      end
      5: begin
        stream_text.push_back("\"");
        n = $urandom_range(0, 6);
        for (i = 0; i < n; i++) begin
          do b = 8'($urandom_range(0, 255)); while (b == "\"");
          stream_text.push_back(b);
        end
        if ($urandom_range(0, 4) != 0) stream_text.push_back("\"");
      end
      6, 7: stream_text.push_back(ops[$urandom_range(0, ops.len() - 1)]);
      8: begin
        stream_text.push_back($urandom_range(0, 1) ? "<" : ">");
        stream_text.push_back("=");
      end
      9: begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) append_space();
      end
      default: stream_text.push_back(8'($urandom_range(0, 255)));
    endcase
    if ($urandom_range(0, 1) == 0) append_space();
  endfunction

  task automatic test_byte_extremes();
    stream_text.delete();
    stream_text.push_back(8'h00);
    stream_text.push_back(8'hFF);
    stream_text.push_back(8'h80);
    stream_text.push_back(8'h7F);
    send_stream();
  endtask

  task automatic test_numbers();
    // second dot splits, trailing dot stays in the number
    load_text("1.2.3 7.");
    send_stream();
  endtask

  task automatic test_comparisons();
    // last char flushes a word, a lone greater and adds the end word
    load_text("<=>=<a>");
    send_stream();
  endtask

  task automatic test_words();
    // wrong case, long near-keyword, string left open at end of stream
    load_text("If whilex1\"x");
    send_stream();
  endtask

  task automatic test_long_string();
    int i;
    logic [7:0] b;
    no_idle = 1'b1;
    send_char("\"", 1'b0);
    for (i = 0; i < LONG_STRING_CHARS; i++) begin
      do b = 8'($urandom_range(0, 255)); while (b == "\"");
      send_char(b, 1'b0);
    end
    send_char("\"", 1'b0);
    send_char(" ", 1'b1);
    no_idle = 1'b0;
  endtask

  task automatic test_random_streams();
    int first;
    int target;
    bit drained;
    first = chars_sent;
    drained = 1'b0;
    while (chars_sent - first < RANDOM_CHARS) begin
      stream_text.delete();
      target = $urandom_range(1, 30);
      while (stream_text.size() < target) append_token();
      no_idle = $urandom_range(0, 5) == 0;
      send_stream();
      if (!drained && chars_sent - first > RANDOM_CHARS / 2) begin
        drained = 1'b1;
        wait_for_drain();
      end
    end
    no_idle = 1'b0;
  endtask

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : token_checker
    token_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) begin
        $error("unexpected token word: kind %0d start_pos %0d", kind, start_pos);
        mismatch_count++;
      end else begin
        want = pending_tokens.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, kind);
          mismatch_count++;
        end
        if (start_pos !== want.start_pos) begin
          $error("start_pos: expected %0d, actual %0d", want.start_pos, start_pos);
          mismatch_count++;
        end
        if (length !== want.length) begin
          $error("length: expected %0d, actual %0d", want.length, length);
          mismatch_count++;
        end
        if (length_saturated !== want.sat) begin
          $error("length_saturated: expected %0d, actual %0d", want.sat, length_saturated);
          mismatch_count++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, actual %0d", want.last, last_of_run);
          mismatch_count++;
        end
      end
      out_stall = no_idle ? 0 : $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    open_token(SCAN_IDLE, 32'd0, 16'd0);
    stream_pos = 32'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_byte_extremes();
    test_numbers();
    test_comparisons();
    test_words();
    test_long_string();
    test_random_streams();

    wait_for_drain();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
